### rtl/mmsc_pkg.sv
package mmsc_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int PAGE_W = 21;
  localparam int CFG_IDX_W = 1;

  localparam logic [PAGE_W-1:0] PAGE_SIZE_RST = 21'd4096;
  localparam logic [63:0] USABLE_MASK_RST = 64'd128;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USABLE_MASK = 1'd1;

  typedef struct packed {
    logic [63:0] desc_base;
    logic [63:0] desc_pages;
    logic [5:0]  desc_type;
    logic        desc_last;
  } desc_t;

  typedef struct packed {
    logic [63:0] out_base;
    logic [63:0] out_pages;
    logic        out_valid;
    logic        out_overflow;
    logic        out_last;
  } result_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] pages;
    logic [5:0]  typ;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_INIT,
    ST_SORT_RD,
    ST_SORT_HOLD,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_WALK_INIT,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_RUN_END,
    ST_JOIN_CHK,
    ST_COMMIT_LAST,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SORT_INIT,
    OP_SORT_RD,
    OP_SORT_HOLD,
    OP_SORT_SHIFT,
    OP_SORT_PLACE,
    OP_WALK_INIT,
    OP_WALK_RD,
    OP_WALK_SKIP,
    OP_WALK_START,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_RUN_END,
    OP_JOIN,
    OP_COMMIT
  } op_t;

  // OP_FINISH shares no encoding room above; finish is signaled separately
  typedef struct packed {
    op_t  op;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic few;        // at most one entry stored
    logic gt;         // read entry base above held entry base
    logic k_one;
    logic sort_last;
    logic usable;
    logic join_ok;
    logic at_end;
    logic next_end;
  } dp_status_t;

endpackage

### rtl/mmsc_dp.sv
module mmsc_dp #(
  parameter int MaxEntries = mmsc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mmsc_pkg::dp_cmd_t              cmd,
  input  mmsc_pkg::desc_t                desc,
  input  logic                           cfg_we,
  input  logic [mmsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  output mmsc_pkg::dp_status_t           status,
  output logic                           out_strobe,
  output mmsc_pkg::result_t              result
);
  import mmsc_pkg::*;

  localparam int AW = $clog2(MaxEntries);
  localparam int CW = $clog2(MaxEntries + 1);

  entry_t mem [MaxEntries];
  entry_t rd_data;
  entry_t hold;
  entry_t wr_data;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] k;
  logic [CW-1:0] i_p1;
  logic [CW-1:0] i_m1;
  logic [CW-1:0] k_m2;
  logic          dropped;
  logic          room;

  logic [PAGE_W-1:0] page_size;
  logic [63:0]       usable_mask;

  logic [63:0] run_base;
  logic [63:0] run_pages;
  logic [63:0] run_end;
  logic [52:0] prod_lo;
  logic [31:0] prod_hi;
  logic [63:0] pend_base;
  logic [63:0] pend_pages;
  logic        pend_valid;

  assign i_p1 = i + CW'(1);
  assign i_m1 = i - CW'(1);
  assign k_m2 = k - CW'(2);
  assign room = count < CW'(MaxEntries);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = k[AW-1:0];
    wr_data = hold;
    case (cmd.op)
      OP_LOAD: begin
        wr_en   = room;
        wr_addr = count[AW-1:0];
        wr_data = '{base: desc.desc_base, pages: desc.desc_pages, typ: desc.desc_type};
      end
      OP_SORT_RD: rd_en = 1'b1;
      OP_SORT_HOLD: begin
        rd_en   = 1'b1;
        rd_addr = i_m1[AW-1:0];
      end
      OP_SORT_SHIFT: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        rd_en   = (k != CW'(1));
        rd_addr = k_m2[AW-1:0];
      end
      OP_SORT_PLACE: wr_en = 1'b1;
      OP_WALK_RD: rd_en = 1'b1;
      OP_RUN_END: rd_en = (i != count);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    status.few       = (count <= CW'(1));
    status.gt        = (rd_data.base > hold.base);
    status.k_one     = (k == CW'(1));
    status.sort_last = (i_p1 == count);
    status.usable    = usable_mask[rd_data.typ];
    status.join_ok   = usable_mask[rd_data.typ] && (rd_data.base == run_end);
    status.at_end    = (i == count);
    status.next_end  = (i_p1 == count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      dropped     <= 1'b0;
      pend_valid  <= 1'b0;
      out_strobe  <= 1'b0;
      page_size   <= PAGE_SIZE_RST;
      usable_mask <= USABLE_MASK_RST;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_PAGE_SIZE:   page_size <= cfg_data[PAGE_W-1:0];
          REG_USABLE_MASK: usable_mask <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          if (room) begin
            count <= count + CW'(1);
          end else begin
            dropped <= 1'b1;
          end
        end
        OP_SORT_INIT: i <= CW'(1);
        OP_SORT_HOLD: begin
          hold <= rd_data;
          k    <= i;
        end
        OP_SORT_SHIFT: k <= k - CW'(1);
        OP_SORT_PLACE: i <= i_p1;
        OP_WALK_INIT:  i <= '0;
        OP_WALK_SKIP:  i <= i_p1;
        OP_WALK_START: begin
          run_base  <= rd_data.base;
          run_pages <= rd_data.pages;
          i         <= i_p1;
        end
        OP_MUL_LO: prod_lo <= run_pages[31:0] * page_size;
        OP_MUL_HI: prod_hi <= 32'(run_pages[63:32] * page_size);
        OP_RUN_END: run_end <= run_base + 64'(prod_lo) + {prod_hi, 32'd0};
        OP_JOIN: begin
          run_pages <= run_pages + rd_data.pages;
          i         <= i_p1;
        end
        OP_COMMIT: begin
          // previous run goes out only now that another one is known to follow
          if (pend_valid) begin
            out_strobe <= 1'b1;
            result     <= '{out_base: pend_base, out_pages: pend_pages, out_valid: 1'b1,
                            out_overflow: dropped, out_last: 1'b0};
          end
          pend_base  <= run_base;
          pend_pages <= run_pages;
          pend_valid <= 1'b1;
        end
        default: ;
      endcase
      if (cmd.finish) begin
        out_strobe <= 1'b1;
        result     <= '{out_base: pend_valid ? pend_base : 64'd0,
                        out_pages: pend_valid ? pend_pages : 64'd0,
                        out_valid: pend_valid, out_overflow: dropped, out_last: 1'b1};
        pend_valid <= 1'b0;
        count      <= '0;
        dropped    <= 1'b0;
      end
    end
  end

endmodule

### rtl/mmsc_ctrl.sv
module mmsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 last,
  input  mmsc_pkg::dp_status_t status,
  output mmsc_pkg::dp_cmd_t    cmd,
  output logic                 busy
);
  import mmsc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (last) begin
            state_next = ST_SORT_INIT;
          end
        end
      end
      ST_SORT_INIT: begin
        cmd.op     = OP_SORT_INIT;
        state_next = status.few ? ST_WALK_INIT : ST_SORT_RD;
      end
      ST_SORT_RD: begin
        cmd.op     = OP_SORT_RD;
        state_next = ST_SORT_HOLD;
      end
      ST_SORT_HOLD: begin
        cmd.op     = OP_SORT_HOLD;
        state_next = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        if (status.gt) begin
          cmd.op = OP_SORT_SHIFT;
          if (status.k_one) begin
            state_next = ST_SORT_PLACE;
          end
        end else begin
          cmd.op     = OP_SORT_PLACE;
          state_next = status.sort_last ? ST_WALK_INIT : ST_SORT_RD;
        end
      end
      ST_SORT_PLACE: begin
        cmd.op     = OP_SORT_PLACE;
        state_next = status.sort_last ? ST_WALK_INIT : ST_SORT_RD;
      end
      ST_WALK_INIT: begin
        cmd.op     = OP_WALK_INIT;
        state_next = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        cmd.op     = OP_WALK_RD;
        state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (status.usable) begin
          cmd.op     = OP_WALK_START;
          state_next = ST_MUL_LO;
        end else begin
          cmd.op     = OP_WALK_SKIP;
          state_next = status.next_end ? ST_FINISH : ST_WALK_RD;
        end
      end
      ST_MUL_LO: begin
        cmd.op     = OP_MUL_LO;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.op     = OP_MUL_HI;
        state_next = ST_RUN_END;
      end
      ST_RUN_END: begin
        cmd.op     = OP_RUN_END;
        state_next = status.at_end ? ST_COMMIT_LAST : ST_JOIN_CHK;
      end
      ST_JOIN_CHK: begin
        if (status.join_ok) begin
          cmd.op     = OP_JOIN;
          state_next = ST_MUL_LO;
        end else begin
          // read data still holds this entry; recheck it as a new run start
          cmd.op     = OP_COMMIT;
          state_next = ST_WALK_CHK;
        end
      end
      ST_COMMIT_LAST: begin
        cmd.op     = OP_COMMIT;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/memory_map_sort_and_coalesce.sv
// Load: one descriptor per cycle while idle; busy rises after the last one.
// Sort: stable insertion sort over one memory port pair; each entry is read, held and
//   compared, and entries with a greater base are shifted up before it is placed.
// Merge walk: unusable entries are skipped; a run opens at a usable one, its end from a
//   split 64x21 multiply, abutting usable entries join; the final result follows the walk.
// Results appear one cycle each on out_strobe; the receiver cannot stall.
// Reset: controller idle, store empty, registers at defaults; no clearing pass.
module memory_map_sort_and_coalesce #(
  parameter int MaxEntries = mmsc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  mmsc_pkg::desc_t                desc,
  output logic                           out_strobe,
  output mmsc_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [mmsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);
  import mmsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mmsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (desc.desc_last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mmsc_dp #(
    .MaxEntries (MaxEntries)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .desc       (desc),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .out_strobe (out_strobe),
    .result     (result)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    out_strobe && !result.out_last |-> busy)
    else $error("result transfer while idle");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_strobe && result.out_last |-> !busy)
    else $error("still busy during final result");

  a_invalid_last: assert property (@(posedge clk) disable iff (rst)
    out_strobe && !result.out_valid |-> result.out_last)
    else $error("empty result not marked last");

endmodule
